>>> sv/coordinate_frame_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the coordinate frame parser.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and disabled while the synchronous reset is held low.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_FRAME_PARSER_CORE_MACROS_SVH
`define COORDINATE_FRAME_PARSER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("coordinate frame parser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("coordinate frame parser: next-cycle check failed");

`endif

>>> sv/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Types, codes and constants shared by the coordinate frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

    localparam int unsigned COORD_W     = 10;
    localparam int unsigned COORD_SLOTS = 8;
    localparam int unsigned SLOT_W      = 3;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned STATUS_W    = 2;

    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [STATUS_W-1:0] t_status;

    // Parser state codes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_RECT  = 2'd2;

    // Result status codes.
    localparam t_status STATUS_POINT = 2'd0;
    localparam t_status STATUS_RECT  = 2'd1;
    localparam t_status STATUS_BAD   = 2'd2;

    // Header and digit characters.
    localparam logic [7:0] CHAR_POINT = 8'h6A; // 'j'
    localparam logic [7:0] CHAR_RECT  = 8'h72; // 'r'
    localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39; // '9'

    // Characters per frame after the header.
    localparam logic [COUNT_W-1:0] POINT_CHARS = 5'd6;
    localparam logic [COUNT_W-1:0] RECT_CHARS  = 5'd24;

endpackage

`default_nettype wire

>>> sv/coordinate_frame_parser_core.sv
// ----------------------------------------------------------------------------
// coordinate_frame_parser_core
// Byte-serial parser for point and rectangle coordinate frames.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                    Word
//   -------  ---------  ---------------------------  ------------------------------
//   in       input      i_in_valid / o_in_ready      i_rx_byte
//   out      output     o_out_valid / i_out_ready    o_frame_status, o_coord_0..7
//
// A byte is taken into an input register and processed from there by a
// single accumulate step; the result of a frame is captured in the output
// register when its last byte leaves the input register. A finished result
// waits in the output register while later bytes are still accepted; only
// a byte that would finish another frame stalls behind it. Apart from that
// stall, one byte is accepted every cycle; the rate is set by the
// accumulate step on the selected coordinate register. The synchronous
// active-low reset returns the parser to idle and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coordinate_frame_parser_core_macros.svh"

module coordinate_frame_parser_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire  [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output cfp_pkg::t_status     o_frame_status,
    output cfp_pkg::t_coord      o_coord_0,
    output cfp_pkg::t_coord      o_coord_1,
    output cfp_pkg::t_coord      o_coord_2,
    output cfp_pkg::t_coord      o_coord_3,
    output cfp_pkg::t_coord      o_coord_4,
    output cfp_pkg::t_coord      o_coord_5,
    output cfp_pkg::t_coord      o_coord_6,
    output cfp_pkg::t_coord      o_coord_7
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parser state. The slot and digit position track char_count / 3 and
    // char_count % 3 incrementally, so no divider is needed.
    logic [1:0]                      r_mode;
    logic [cfp_pkg::COUNT_W-1:0]     r_char_count;
    logic [cfp_pkg::SLOT_W-1:0]      r_slot;
    logic [1:0]                      r_digit_pos;
    logic                            r_digit_error;
    cfp_pkg::t_coord                 r_coord [cfp_pkg::COORD_SLOTS];

    // Output register.
    logic                            r_out_valid;
    cfp_pkg::t_status                r_out_status;
    cfp_pkg::t_coord                 r_out_coord [cfp_pkg::COORD_SLOTS];

    logic                            w_in_frame;
    logic [cfp_pkg::COUNT_W-1:0]     w_need;
    logic [cfp_pkg::COUNT_W-1:0]     w_count_inc;
    logic                            w_fin;
    logic                            w_adv;
    logic                            w_is_digit;
    logic [3:0]                      w_digit;
    logic [13:0]                     w_acc;
    cfp_pkg::t_coord                 n_coord;
    cfp_pkg::t_status                n_status;

    // Code 3 of the mode register never occurs; it behaves as idle.
    assign w_in_frame  = (r_mode == cfp_pkg::MODE_POINT) || (r_mode == cfp_pkg::MODE_RECT);
    assign w_need      = (r_mode == cfp_pkg::MODE_POINT) ? cfp_pkg::POINT_CHARS
                                                         : cfp_pkg::RECT_CHARS;
    assign w_count_inc = r_char_count + 5'd1;
    assign w_fin       = r_in_valid && w_in_frame && (w_count_inc == w_need);

    // The held byte moves on unless it finishes a frame while the previous
    // result is still waiting to be taken.
    assign w_adv      = r_in_valid && (!w_fin || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // Decimal accumulate: coord * 10 + digit, kept to the coordinate width.
    assign w_is_digit = (r_in_byte >= cfp_pkg::CHAR_ZERO) && (r_in_byte <= cfp_pkg::CHAR_NINE);
    assign w_digit    = 4'(r_in_byte - cfp_pkg::CHAR_ZERO);
    assign w_acc      = ({4'd0, r_coord[r_slot]} << 3) + ({4'd0, r_coord[r_slot]} << 1)
                      + {10'd0, w_digit};
    assign n_coord    = w_acc[cfp_pkg::COORD_W-1:0];

    always_comb begin
        if (r_digit_error || !w_is_digit) begin
            n_status = cfp_pkg::STATUS_BAD;
        end else if (r_mode == cfp_pkg::MODE_POINT) begin
            n_status = cfp_pkg::STATUS_POINT;
        end else begin
            n_status = cfp_pkg::STATUS_RECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= cfp_pkg::MODE_IDLE;
            r_char_count  <= '0;
            r_slot        <= '0;
            r_digit_pos   <= '0;
            r_digit_error <= 1'b0;
            for (int i = 0; i < cfp_pkg::COORD_SLOTS; i++) begin
                r_coord[i] <= '0;
            end
        end else if (w_adv) begin
            if (!w_in_frame) begin
                // Idle: a header opens a fresh frame, anything else is dropped.
                if (r_in_byte == cfp_pkg::CHAR_POINT || r_in_byte == cfp_pkg::CHAR_RECT) begin
                    r_mode        <= (r_in_byte == cfp_pkg::CHAR_POINT) ? cfp_pkg::MODE_POINT
                                                                        : cfp_pkg::MODE_RECT;
                    r_char_count  <= '0;
                    r_slot        <= '0;
                    r_digit_pos   <= '0;
                    r_digit_error <= 1'b0;
                    for (int i = 0; i < cfp_pkg::COORD_SLOTS; i++) begin
                        r_coord[i] <= '0;
                    end
                end
            end else if (w_fin) begin
                // Last character: the result is captured below, state clears.
                r_mode        <= cfp_pkg::MODE_IDLE;
                r_char_count  <= '0;
                r_slot        <= '0;
                r_digit_pos   <= '0;
                r_digit_error <= 1'b0;
                for (int i = 0; i < cfp_pkg::COORD_SLOTS; i++) begin
                    r_coord[i] <= '0;
                end
            end else begin
                if (w_is_digit) begin
                    r_coord[r_slot] <= n_coord;
                end else begin
                    r_digit_error <= 1'b1;
                end
                r_char_count <= w_count_inc;
                if (r_digit_pos == 2'd2) begin
                    r_digit_pos <= 2'd0;
                    r_slot      <= r_slot + 3'd1;
                end else begin
                    r_digit_pos <= r_digit_pos + 2'd1;
                end
            end
        end
    end

    // Result register. A bad frame reports all coordinates as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && w_fin) begin
            r_out_status <= n_status;
            for (int i = 0; i < cfp_pkg::COORD_SLOTS; i++) begin
                if (n_status == cfp_pkg::STATUS_BAD) begin
                    r_out_coord[i] <= '0;
                end else if (i == int'(r_slot)) begin
                    r_out_coord[i] <= n_coord;
                end else begin
                    r_out_coord[i] <= r_coord[i];
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_out_status;
    assign o_coord_0      = r_out_coord[0];
    assign o_coord_1      = r_out_coord[1];
    assign o_coord_2      = r_out_coord[2];
    assign o_coord_3      = r_out_coord[3];
    assign o_coord_4      = r_out_coord[4];
    assign o_coord_5      = r_out_coord[5];
    assign o_coord_6      = r_out_coord[6];
    assign o_coord_7      = r_out_coord[7];

    // The character count never reaches the frame length inside a frame.
    `CFP_ASSERT_SAME(a_count_in_range, i_clk, i_rst_n, w_in_frame, r_char_count < w_need)
    // While idle the frame counters rest at zero.
    `CFP_ASSERT_SAME(a_idle_clear, i_clk, i_rst_n, !w_in_frame,
        (r_char_count == '0) && (r_slot == '0) && (r_digit_pos == '0) && !r_digit_error)
    // A bad frame reports zero coordinates.
    `CFP_ASSERT_SAME(a_bad_zero, i_clk, i_rst_n,
        o_out_valid && (o_frame_status == cfp_pkg::STATUS_BAD),
        (o_coord_0 == '0) && (o_coord_1 == '0) && (o_coord_7 == '0))
    // A point frame leaves the rectangle-only coordinates zero.
    `CFP_ASSERT_SAME(a_point_unused, i_clk, i_rst_n,
        o_out_valid && (o_frame_status == cfp_pkg::STATUS_POINT),
        (o_coord_2 == '0) && (o_coord_3 == '0) && (o_coord_4 == '0) && (o_coord_5 == '0)
        && (o_coord_6 == '0) && (o_coord_7 == '0))
    // Finishing a frame always puts the parser back to idle.
    `CFP_ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, w_adv && w_fin, r_mode == cfp_pkg::MODE_IDLE)

endmodule

`default_nettype wire

>>> sim/coordinate_frame_parser_core_checker.sv
// ----------------------------------------------------------------------------
// coordinate_frame_parser_core_checker
// Watches both channels of the frame parser. It decodes every accepted byte
// with its own copy of the parser state, queues the frame words that must
// come out, and compares each accepted output word field by field.
// ----------------------------------------------------------------------------
module coordinate_frame_parser_core_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  wire  [7:0]        i_rx_byte,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  cfp_pkg::t_status  i_frame_status,
    input  cfp_pkg::t_coord   i_coord_0,
    input  cfp_pkg::t_coord   i_coord_1,
    input  cfp_pkg::t_coord   i_coord_2,
    input  cfp_pkg::t_coord   i_coord_3,
    input  cfp_pkg::t_coord   i_coord_4,
    input  cfp_pkg::t_coord   i_coord_5,
    input  cfp_pkg::t_coord   i_coord_6,
    input  cfp_pkg::t_coord   i_coord_7,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_results
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cfp_pkg::t_status status;
        cfp_pkg::t_coord  coord [cfp_pkg::COORD_SLOTS];
    } t_frame_word;

    t_frame_word frames_due [$];

    logic [1:0]                  parse_mode;
    logic [cfp_pkg::COUNT_W-1:0] chars_taken;
    cfp_pkg::t_coord             coord_acc [cfp_pkg::COORD_SLOTS];
    logic                        saw_bad_digit;

    int mismatch_total = 0;
    int result_total   = 0;

    task automatic open_frame(input logic [1:0] mode);
        parse_mode    = mode;
        chars_taken   = '0;
        saw_bad_digit = 1'b0;
        for (int k = 0; k < cfp_pkg::COORD_SLOTS; k++) begin
            coord_acc[k] = '0;
        end
    endtask

    // Advances the parser copy by one byte and queues a frame word when
    // the byte completes a frame.
    task automatic decode_byte(input logic [7:0] rx);
        t_frame_word                 word;
        int unsigned                 slot;
        logic [cfp_pkg::COUNT_W-1:0] frame_len;
        logic [13:0]                 sum;
        if (parse_mode != cfp_pkg::MODE_POINT && parse_mode != cfp_pkg::MODE_RECT) begin
            if (rx == cfp_pkg::CHAR_POINT) begin
                open_frame(cfp_pkg::MODE_POINT);
            end else if (rx == cfp_pkg::CHAR_RECT) begin
                open_frame(cfp_pkg::MODE_RECT);
            end
            return;
        end
        frame_len = (parse_mode == cfp_pkg::MODE_POINT) ? cfp_pkg::POINT_CHARS
                                                        : cfp_pkg::RECT_CHARS;
        slot = (int'(chars_taken) / 3) % cfp_pkg::COORD_SLOTS;
        if (rx >= cfp_pkg::CHAR_ZERO && rx <= cfp_pkg::CHAR_NINE) begin
            sum = 14'(coord_acc[slot]) * 14'd10 + 14'(rx - cfp_pkg::CHAR_ZERO);
            coord_acc[slot] = sum[cfp_pkg::COORD_W-1:0];
        end else begin
            saw_bad_digit = 1'b1;
        end
        chars_taken = chars_taken + 1'b1;
        if (chars_taken < frame_len) begin
            return;
        end
        if (saw_bad_digit) begin
            word.status = cfp_pkg::STATUS_BAD;
        end else begin
            word.status = (parse_mode == cfp_pkg::MODE_POINT) ? cfp_pkg::STATUS_POINT
                                                              : cfp_pkg::STATUS_RECT;
        end
        for (int k = 0; k < cfp_pkg::COORD_SLOTS; k++) begin
            word.coord[k] = saw_bad_digit ? '0 : coord_acc[k];
        end
        frames_due.push_back(word);
        open_frame(cfp_pkg::MODE_IDLE);
    endtask

    task automatic report(input string msg);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    initial begin
        open_frame(cfp_pkg::MODE_IDLE);
    end

    always @(posedge i_clk) begin : watch
        t_frame_word got;
        t_frame_word want;
        if (!i_rst_n) begin
            open_frame(cfp_pkg::MODE_IDLE);
            frames_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                result_total++;
                got.status   = i_frame_status;
                got.coord[0] = i_coord_0;
                got.coord[1] = i_coord_1;
                got.coord[2] = i_coord_2;
                got.coord[3] = i_coord_3;
                got.coord[4] = i_coord_4;
                got.coord[5] = i_coord_5;
                got.coord[6] = i_coord_6;
                got.coord[7] = i_coord_7;
                if (frames_due.size() == 0) begin
                    report($sformatf("word %0d arrived with no frame due (status %0d)",
                                     result_total, got.status));
                end else begin
                    want = frames_due.pop_front();
                    if (got.status !== want.status) begin
                        report($sformatf("word %0d frame_status expected %0d, got %0d",
                                         result_total, want.status, got.status));
                    end
                    for (int k = 0; k < cfp_pkg::COORD_SLOTS; k++) begin
                        if (got.coord[k] !== want.coord[k]) begin
                            report($sformatf("word %0d coord_%0d expected %0d, got %0d",
                                             result_total, k, want.coord[k], got.coord[k]));
                        end
                    end
                end
            end
            // The oldest expectation is consumed before this edge's byte is
            // decoded, so a word can never be matched against its own byte.
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_rx_byte);
            end
        end
        o_pending    <= frames_due.size();
        o_mismatches <= mismatch_total;
        o_results    <= result_total;
    end

endmodule

>>> sim/coordinate_frame_parser_core_test.sv
// ----------------------------------------------------------------------------
// coordinate_frame_parser_core_test
// Drives point and rectangle frames, corrupted and cut-short frames and stray
// bytes into the frame parser, with random gaps on both channels, and gives
// the verdict from the mismatch and pending counts of the checker beside the block.
// ----------------------------------------------------------------------------
module coordinate_frame_parser_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Frame shapes for the random part.
    localparam int SHAPE_CLEAN   = 0;
    localparam int SHAPE_CORRUPT = 1;
    localparam int SHAPE_CUT     = 2;

    localparam int FRAME_BYTES_WANTED = 1750;
    localparam int HOLD_CYCLES        = 300;
    localparam int DRAIN_CYCLES       = 16;
    localparam int IDLE_PERCENT       = 12;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [7:0]        i_rx_byte   = 8'h00;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    cfp_pkg::t_status  o_frame_status;
    cfp_pkg::t_coord   o_coord_0;
    cfp_pkg::t_coord   o_coord_1;
    cfp_pkg::t_coord   o_coord_2;
    cfp_pkg::t_coord   o_coord_3;
    cfp_pkg::t_coord   o_coord_4;
    cfp_pkg::t_coord   o_coord_5;
    cfp_pkg::t_coord   o_coord_6;
    cfp_pkg::t_coord   o_coord_7;

    int mismatches;
    int words_pending;
    int words_checked;

    // Shared between the sender and the receiver: quiet switches off idling on
    // both sides, and each rise of holds_asked starts one long receiver stall.
    bit quiet       = 1'b0;
    int holds_asked = 0;

    int frames_sent  = 0;
    int rect_frames  = 0;
    int rough_frames = 0;
    int frame_bytes  = 0;
    int stray_bytes  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    coordinate_frame_parser_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_status (o_frame_status),
        .o_coord_0      (o_coord_0),
        .o_coord_1      (o_coord_1),
        .o_coord_2      (o_coord_2),
        .o_coord_3      (o_coord_3),
        .o_coord_4      (o_coord_4),
        .o_coord_5      (o_coord_5),
        .o_coord_6      (o_coord_6),
        .o_coord_7      (o_coord_7)
    );

    coordinate_frame_parser_core_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_frame_status (o_frame_status),
        .i_coord_0      (o_coord_0),
        .i_coord_1      (o_coord_1),
        .i_coord_2      (o_coord_2),
        .i_coord_3      (o_coord_3),
        .i_coord_4      (o_coord_4),
        .i_coord_5      (o_coord_5),
        .i_coord_6      (o_coord_6),
        .i_coord_7      (o_coord_7),
        .o_mismatches   (mismatches),
        .o_pending      (words_pending),
        .o_results      (words_checked)
    );

    // Offers one byte and returns at the rising edge at which it is taken.
    // All drives happen just after a rising edge, and ready is read in the
    // same place, so it still shows the value that edge sampled. Valid is
    // only lowered while idling, so it never drops and rises in one step.
    task automatic send_byte(input logic [7:0] rx);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= rx;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++) begin
            send_byte(text[k]);
        end
    endtask

    // Stops offering bytes until every frame word the checker expects has
    // been taken. The first edge lets the checker count the last byte sent.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sends a header and its characters. Coordinates lean towards the
    // extremes; a corrupt frame has random bytes mixed into its digits, and
    // a cut frame stops early so that whatever follows fills it up.
    task automatic send_frame(input int shape, input bit rect);
        int unsigned chars;
        int unsigned value;
        int unsigned place;
        logic [7:0]  ch;
        chars = rect ? cfp_pkg::RECT_CHARS : cfp_pkg::POINT_CHARS;
        if (shape == SHAPE_CUT) begin
            chars = $urandom_range(chars - 1, 1);
        end
        send_byte(rect ? cfp_pkg::CHAR_RECT : cfp_pkg::CHAR_POINT);
        frame_bytes++;
        value = 0;
        for (int d = 0; d < chars; d++) begin
            if (d % 3 == 0) begin
                case ($urandom_range(3))
                    0:       value = 0;
                    1:       value = 999;
                    default: value = $urandom_range(999);
                endcase
            end
            place = (d % 3 == 0) ? 100 : ((d % 3 == 1) ? 10 : 1);
            ch = cfp_pkg::CHAR_ZERO + 8'((value / place) % 10);
            if (shape == SHAPE_CORRUPT && $urandom_range(5) == 0) begin
                ch = 8'($urandom_range(255));
            end
            send_byte(ch);
            frame_bytes++;
        end
    endtask

    // The receiver runs in its own process. Normally it refuses a word in
    // about one cycle of eight; when a hold is asked for it refuses for a
    // long stretch, so that the output register stays full and the parser
    // has to stall the byte that would finish the next frame.
    initial begin : receiver
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done < holds_asked) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin : stimulus
        int pick;
        int shape;
        bit rect;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Stray bytes at both ends of the range are dropped
        // while idle; then two point frames at the coordinate extremes, and one
        // whose characters include the bytes just outside the digit range and
        // both header bytes.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("j999000");
        send_text("j000999");
        send_text("j/0r:9j");
        wait_for_drain();

        // Random part: mostly well-formed frames with random content, with
        // some stray bytes between frames and some damaged frames.
        while (frame_bytes < FRAME_BYTES_WANTED) begin
            if (frames_sent == 10 || frames_sent == 80) begin
                holds_asked++;
            end
            if (frames_sent == 30 || frames_sent == 95) begin
                wait_for_drain();
            end
            quiet = (frames_sent >= 45 && frames_sent < 70);
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(3, 1)) begin
                    send_byte(8'($urandom_range(255)));
                    stray_bytes++;
                end
            end
            pick  = $urandom_range(99);
            shape = (pick < 80) ? SHAPE_CLEAN : ((pick < 92) ? SHAPE_CORRUPT : SHAPE_CUT);
            rect  = 1'($urandom_range(1));
            send_frame(shape, rect);
            frames_sent++;
            if (rect) begin
                rect_frames++;
            end
            if (shape != SHAPE_CLEAN) begin
                rough_frames++;
            end
        end

        // Let the last frame words out, then idle for DRAIN_CYCLES in case a
        // stray word follows.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d random frames (%0d rectangles, %0d corrupted or cut short)",
                 frames_sent, rect_frames, rough_frames);
        $display("in %0d frame bytes and %0d stray bytes; %0d frame words compared.",
                 frame_bytes, stray_bytes, words_checked);
        if (mismatches == 0 && words_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #200000;
        $display("Timed out waiting for the parser.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
